/* design/rcc3d_pkg.sv */
// ----------------------------------------------------------------------------
// rcc3d_pkg: shared constants and helpers for the running centroid unit
// Field widths, derived accumulator widths, pair tables and saturation.
// ----------------------------------------------------------------------------
package rcc3d_pkg;

   // Block parameters
   localparam int MAX_POINTS = 65536;
   localparam int FRAC_BITS  = 8;

   // Field widths
   localparam int COORD_W    = 16;
   localparam int CNT_OUT_W  = 17;
   localparam int MEAN_W     = 24;
   localparam int COV_W      = 40;

   localparam int NUM_COORDS = 3;
   localparam int NUM_PAIRS  = 6;
   localparam int NUM_TERMS  = NUM_COORDS + NUM_PAIRS;

   // Derived internal widths
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int CSUM_W     = COORD_W + CNT_W;
   localparam int PSUM_W     = 2 * COORD_W - 1 + CNT_W;
   localparam int DVD_W      = PSUM_W + FRAC_BITS;
   localparam int MAG_W      = COORD_W + FRAC_BITS;
   localparam int MUL_W      = MAG_W;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int COV_CALC_W = DVD_W + 2;
   localparam int BIT_CNT_W  = $clog2(DVD_W);
   localparam int TERM_IDX_W = $clog2(NUM_TERMS);
   localparam int PAIR_IDX_W = $clog2(NUM_PAIRS);
   localparam int AXIS_W     = $clog2(NUM_COORDS);
   localparam int CNT_CMP_W  = (CNT_W > CNT_OUT_W ? CNT_W : CNT_OUT_W);
   localparam int MEAN_CMP_W = (MAG_W > MEAN_W ? MAG_W : MEAN_W) + 1;

   // Stream widths
   localparam int REQ_DATA_W = 3 * COORD_W;
   localparam int RSP_USED_W = CNT_OUT_W + NUM_COORDS * MEAN_W + NUM_PAIRS * COV_W;
   localparam int RSP_DATA_W = ((RSP_USED_W + 7) / 8) * 8;
   localparam int RSP_PAD_W  = RSP_DATA_W - RSP_USED_W;

   // Saturation limits
   localparam int     CNT_OUT_MAX  = 131071;
   localparam int     MEAN_POS_MAX = 8388607;
   localparam longint COV_POS_MAX  = (64'sd1 <<< (COV_W - 1)) - 64'sd1;
   localparam longint COV_NEG_MIN  = -(64'sd1 <<< (COV_W - 1));

   // Axis codes
   localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
   localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

   // Pair order: xx, xy, xz, yy, yz, zz
   function automatic logic [AXIS_W-1:0] pair_first(input logic [PAIR_IDX_W-1:0] p);
      logic [AXIS_W-1:0] a;
      unique case (p)
         3'd0, 3'd1, 3'd2: a = AXIS_X;
         3'd3, 3'd4:       a = AXIS_Y;
         3'd5:             a = AXIS_Z;
         default:          a = AXIS_X;
      endcase
      return a;
   endfunction

   function automatic logic [AXIS_W-1:0] pair_second(input logic [PAIR_IDX_W-1:0] p);
      logic [AXIS_W-1:0] b;
      unique case (p)
         3'd0:             b = AXIS_X;
         3'd1, 3'd3:       b = AXIS_Y;
         3'd2, 3'd4, 3'd5: b = AXIS_Z;
         default:          b = AXIS_X;
      endcase
      return b;
   endfunction

   function automatic logic [CNT_OUT_W-1:0] sat_count(input logic [CNT_W-1:0] n);
      logic [CNT_CMP_W-1:0] ext;
      logic [CNT_OUT_W-1:0] r;
      ext = CNT_CMP_W'(n);
      if (ext > CNT_CMP_W'(CNT_OUT_MAX)) begin
         r = CNT_OUT_W'(CNT_OUT_MAX);
      end else begin
         r = CNT_OUT_W'(ext);
      end
      return r;
   endfunction

   // Sign-magnitude mean to a saturated two's complement field
   function automatic logic [MEAN_W-1:0] sat_mean(input logic neg,
                                                  input logic [MAG_W-1:0] mag);
      logic [MEAN_CMP_W-1:0] ext;
      logic [MEAN_CMP_W-1:0] sv;
      logic [MEAN_W-1:0]     r;
      ext = MEAN_CMP_W'(mag);
      sv  = neg ? (~ext + 1'b1) : ext;
      if (!neg && (ext > MEAN_CMP_W'(MEAN_POS_MAX))) begin
         r = MEAN_W'(MEAN_POS_MAX);
      end else if (neg && (ext > MEAN_CMP_W'(MEAN_POS_MAX + 1))) begin
         r = MEAN_W'(MEAN_POS_MAX + 1);
      end else begin
         r = sv[MEAN_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [COV_W-1:0] sat_cov(input logic signed [COV_CALC_W-1:0] v);
      logic [COV_W-1:0] r;
      if (v > COV_CALC_W'(COV_POS_MAX)) begin
         r = COV_W'(COV_POS_MAX);
      end else if (v < COV_CALC_W'(COV_NEG_MIN)) begin
         r = COV_W'(COV_NEG_MIN);
      end else begin
         r = v[COV_W-1:0];
      end
      return r;
   endfunction

endpackage

/* design/running_centroid_covariance_3d_unit.sv */
// ----------------------------------------------------------------------------
// running_centroid_covariance_3d_unit: running 3-D centroid and covariance
// Accumulates point sums and pair product sums, then divides by the count.
// ----------------------------------------------------------------------------
// Usage
//   req_ channel: one 3-D point per request, tdata = {z, y, x}, 16 bits each,
//   signed. rsp_ channel: one result per request with the point count, the
//   centroid (24 bits each) and six covariance terms (40 bits each), these
//   with FRAC_BITS fraction bits; rsp_tuser flags a point dropped because the
//   buffer already held MAX_POINTS points.
// Timing
//   A shared 1-bit restoring divider runs nine divisions, each a load, one
//   restoring step per dividend bit and a store, one after another.
//   A shared multiplier forms the six coordinate products (skipped on a
//   dropped point) and the six centroid products, overlapped with the
//   divisions. At defaults DVD_W = 56. req_tready is high only between requests.
// Reset
//   Synchronous, active high: count and all sums cleared, rsp_tvalid low.
// Back-pressure
//   The result sits in an output register; the next request is accepted and
//   worked on while it waits, and the block holds its finished result until
//   the register frees up.
// ----------------------------------------------------------------------------
module running_centroid_covariance_3d_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // x [15:0], y [31:16], z [47:32]
   input  logic [rcc3d_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // point_count, mean_x, mean_y, mean_z, cov_xx, cov_xy, cov_xz,
   // cov_yy, cov_yz, cov_zz, zero pad (low to high)
   output logic [rcc3d_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // full_flag
   output logic                                rsp_tuser
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PMUL,    // coordinate product into the product register
      ST_PACC,    // add product into the rotating product sums
      ST_DLOAD,   // load dividend, start centroid product
      ST_DITER,   // one quotient bit per cycle
      ST_DSTORE,  // sign, saturate; covariance terms also subtract the centroid product
      ST_OUT
   } state_type;

   state_type state_ff;

   // architectural state
   logic [rcc3d_pkg::CNT_W-1:0]          count_ff;
   logic signed [rcc3d_pkg::CSUM_W-1:0]  csum_ff [rcc3d_pkg::NUM_COORDS];
   logic signed [rcc3d_pkg::PSUM_W-1:0]  psum_ff [rcc3d_pkg::NUM_PAIRS];

   // sequencer
   logic [rcc3d_pkg::TERM_IDX_W-1:0]     idx_ff;
   logic [rcc3d_pkg::BIT_CNT_W-1:0]      bitcnt_ff;
   logic                                 full_ff;

   // working point, sign-magnitude
   logic [rcc3d_pkg::COORD_W-1:0]        pt_mag_ff [rcc3d_pkg::NUM_COORDS];
   logic                                 pt_neg_ff [rcc3d_pkg::NUM_COORDS];

   // shared multiplier
   logic [rcc3d_pkg::PROD_W-1:0]         prod_ff;
   logic                                 prod_neg_ff;
   logic [rcc3d_pkg::PROD_W-1:0]         mul_in;
   logic                                 mul_neg_in;
   logic [rcc3d_pkg::MUL_W-1:0]          mul_a;
   logic [rcc3d_pkg::MUL_W-1:0]          mul_b;
   logic [rcc3d_pkg::AXIS_W-1:0]         ax_a;
   logic [rcc3d_pkg::AXIS_W-1:0]         ax_b;
   logic [rcc3d_pkg::PAIR_IDX_W-1:0]     pair_sel;

   // shared divider: dividend shifts out, quotient shifts in
   logic [rcc3d_pkg::DVD_W-1:0]          dvd_ff;
   logic [rcc3d_pkg::CNT_W-1:0]          rem_ff;
   logic                                 op_neg_ff;
   logic [rcc3d_pkg::CNT_W:0]            trial;
   logic                                 qbit;
   logic [rcc3d_pkg::CNT_W-1:0]          rem_in;
   logic [rcc3d_pkg::DVD_W-1:0]          dvd_load_in;
   logic                                 op_neg_load_in;

   // results
   logic [rcc3d_pkg::MAG_W-1:0]          mean_mag_ff [rcc3d_pkg::NUM_COORDS];
   logic                                 mean_neg_ff [rcc3d_pkg::NUM_COORDS];
   logic [rcc3d_pkg::MEAN_W-1:0]         mean_out_ff [rcc3d_pkg::NUM_COORDS];
   logic [rcc3d_pkg::COV_W-1:0]          cov_out_ff  [rcc3d_pkg::NUM_PAIRS];
   logic signed [rcc3d_pkg::COV_CALC_W-1:0] cov_in;
   logic signed [rcc3d_pkg::PSUM_W-1:0]  psum_add_in;

   logic                                 rsp_tvalid_ff;
   logic [rcc3d_pkg::RSP_DATA_W-1:0]     rsp_tdata_ff;
   logic                                 rsp_tuser_ff;

   logic                                 req_fire;
   logic                                 full_now;
   logic                                 is_mean_term;
   logic [rcc3d_pkg::AXIS_W-1:0]         axis_sel;
   logic signed [rcc3d_pkg::COORD_W-1:0] pt_in [rcc3d_pkg::NUM_COORDS];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign full_now   = (count_ff >= rcc3d_pkg::CNT_W'(rcc3d_pkg::MAX_POINTS));
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

   assign pt_in[0] = req_tdata[rcc3d_pkg::COORD_W-1:0];
   assign pt_in[1] = req_tdata[2*rcc3d_pkg::COORD_W-1:rcc3d_pkg::COORD_W];
   assign pt_in[2] = req_tdata[3*rcc3d_pkg::COORD_W-1:2*rcc3d_pkg::COORD_W];

   assign is_mean_term = (idx_ff < rcc3d_pkg::TERM_IDX_W'(rcc3d_pkg::NUM_COORDS));
   assign axis_sel     = idx_ff[rcc3d_pkg::AXIS_W-1:0];

   // pair index: product phase counts pairs directly, division phase
   // counts terms with the three centroid terms first
   always_comb begin
      if (state_ff == ST_PMUL) begin
         pair_sel = idx_ff[rcc3d_pkg::PAIR_IDX_W-1:0];
      end else begin
         pair_sel = rcc3d_pkg::PAIR_IDX_W'(idx_ff
                    - rcc3d_pkg::TERM_IDX_W'(rcc3d_pkg::NUM_COORDS));
      end
   end

   assign ax_a = rcc3d_pkg::pair_first(pair_sel);
   assign ax_b = rcc3d_pkg::pair_second(pair_sel);

   // shared unsigned multiplier on magnitudes, sign carried alongside
   always_comb begin
      if (state_ff == ST_PMUL) begin
         mul_a      = rcc3d_pkg::MUL_W'(pt_mag_ff[ax_a]);
         mul_b      = rcc3d_pkg::MUL_W'(pt_mag_ff[ax_b]);
         mul_neg_in = pt_neg_ff[ax_a] ^ pt_neg_ff[ax_b];
      end else begin
         mul_a      = mean_mag_ff[ax_a];
         mul_b      = mean_mag_ff[ax_b];
         mul_neg_in = mean_neg_ff[ax_a] ^ mean_neg_ff[ax_b];
      end
      mul_in = rcc3d_pkg::PROD_W'(mul_a) * rcc3d_pkg::PROD_W'(mul_b);
   end

   always_comb begin
      logic [rcc3d_pkg::PSUM_W-1:0] ext;
      ext = rcc3d_pkg::PSUM_W'(prod_ff[2*rcc3d_pkg::COORD_W-1:0]);
      if (prod_neg_ff) begin
         psum_add_in = psum_ff[0] - $signed(ext);
      end else begin
         psum_add_in = psum_ff[0] + $signed(ext);
      end
   end

   // dividend: magnitude of the selected sum, scaled by the fraction bits
   always_comb begin
      logic signed [rcc3d_pkg::CSUM_W-1:0] cs;
      logic [rcc3d_pkg::CSUM_W-1:0]        cmag;
      logic [rcc3d_pkg::PSUM_W-1:0]        pmag;
      cs   = csum_ff[axis_sel];
      cmag = cs[rcc3d_pkg::CSUM_W-1] ? (~cs + 1'b1) : cs;
      pmag = psum_ff[0][rcc3d_pkg::PSUM_W-1] ? (~psum_ff[0] + 1'b1) : psum_ff[0];
      if (is_mean_term) begin
         dvd_load_in    = rcc3d_pkg::DVD_W'(cmag) << rcc3d_pkg::FRAC_BITS;
         op_neg_load_in = cs[rcc3d_pkg::CSUM_W-1];
      end else begin
         dvd_load_in    = rcc3d_pkg::DVD_W'(pmag) << rcc3d_pkg::FRAC_BITS;
         op_neg_load_in = psum_ff[0][rcc3d_pkg::PSUM_W-1];
      end
   end

   // one restoring step
   assign trial  = {rem_ff, dvd_ff[rcc3d_pkg::DVD_W-1]};
   assign qbit   = (trial >= {1'b0, count_ff});
   assign rem_in = qbit ? rcc3d_pkg::CNT_W'(trial - {1'b0, count_ff})
                        : trial[rcc3d_pkg::CNT_W-1:0];

   // covariance = signed quotient - signed centroid product
   always_comb begin
      logic signed [rcc3d_pkg::COV_CALC_W-1:0] q_s;
      logic signed [rcc3d_pkg::COV_CALC_W-1:0] p_s;
      q_s = $signed(rcc3d_pkg::COV_CALC_W'(dvd_ff));
      p_s = $signed(rcc3d_pkg::COV_CALC_W'(prod_ff >> rcc3d_pkg::FRAC_BITS));
      if (op_neg_ff) begin
         q_s = -q_s;
      end
      if (prod_neg_ff) begin
         p_s = -p_s;
      end
      cov_in = q_s - p_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         idx_ff        <= '0;
         bitcnt_ff     <= '0;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < rcc3d_pkg::NUM_COORDS; i++) begin
            csum_ff[i] <= '0;
         end
         for (int i = 0; i < rcc3d_pkg::NUM_PAIRS; i++) begin
            psum_ff[i] <= '0;
         end
      end else begin
         // the output state reloads the register itself
         if (rsp_tvalid_ff && rsp_tready && (state_ff != ST_OUT)) begin
            rsp_tvalid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  full_ff <= full_now;
                  idx_ff  <= '0;
                  for (int i = 0; i < rcc3d_pkg::NUM_COORDS; i++) begin
                     pt_neg_ff[i] <= pt_in[i][rcc3d_pkg::COORD_W-1];
                     pt_mag_ff[i] <= pt_in[i][rcc3d_pkg::COORD_W-1]
                                     ? (~pt_in[i] + 1'b1) : pt_in[i];
                  end
                  if (full_now) begin
                     state_ff <= ST_DLOAD;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                     for (int i = 0; i < rcc3d_pkg::NUM_COORDS; i++) begin
                        csum_ff[i] <= csum_ff[i] + rcc3d_pkg::CSUM_W'(pt_in[i]);
                     end
                     state_ff <= ST_PMUL;
                  end
               end
            end

            ST_PMUL: begin
               prod_ff     <= mul_in;
               prod_neg_ff <= mul_neg_in;
               state_ff    <= ST_PACC;
            end

            ST_PACC: begin
               // rotate: the updated sum goes to the back of the line
               for (int i = 0; i < rcc3d_pkg::NUM_PAIRS - 1; i++) begin
                  psum_ff[i] <= psum_ff[i+1];
               end
               psum_ff[rcc3d_pkg::NUM_PAIRS-1] <= psum_add_in;
               if (idx_ff == rcc3d_pkg::TERM_IDX_W'(rcc3d_pkg::NUM_PAIRS - 1)) begin
                  idx_ff   <= '0;
                  state_ff <= ST_DLOAD;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_PMUL;
               end
            end

            ST_DLOAD: begin
               dvd_ff    <= dvd_load_in;
               op_neg_ff <= op_neg_load_in;
               rem_ff    <= '0;
               bitcnt_ff <= '0;
               if (!is_mean_term) begin
                  prod_ff     <= mul_in;
                  prod_neg_ff <= mul_neg_in;
                  for (int i = 0; i < rcc3d_pkg::NUM_PAIRS - 1; i++) begin
                     psum_ff[i] <= psum_ff[i+1];
                  end
                  psum_ff[rcc3d_pkg::NUM_PAIRS-1] <= psum_ff[0];
               end
               state_ff <= ST_DITER;
            end

            ST_DITER: begin
               rem_ff    <= rem_in;
               dvd_ff    <= {dvd_ff[rcc3d_pkg::DVD_W-2:0], qbit};
               bitcnt_ff <= bitcnt_ff + 1'b1;
               if (bitcnt_ff == rcc3d_pkg::BIT_CNT_W'(rcc3d_pkg::DVD_W - 1)) begin
                  state_ff <= ST_DSTORE;
               end
            end

            ST_DSTORE: begin
               if (is_mean_term) begin
                  mean_mag_ff[axis_sel] <= dvd_ff[rcc3d_pkg::MAG_W-1:0];
                  mean_neg_ff[axis_sel] <= op_neg_ff;
                  mean_out_ff[axis_sel] <= rcc3d_pkg::sat_mean(op_neg_ff,
                                              dvd_ff[rcc3d_pkg::MAG_W-1:0]);
               end else begin
                  cov_out_ff[pair_sel] <= rcc3d_pkg::sat_cov(cov_in);
               end
               if (idx_ff == rcc3d_pkg::TERM_IDX_W'(rcc3d_pkg::NUM_TERMS - 1)) begin
                  state_ff <= ST_OUT;
               end else begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= ST_DLOAD;
               end
            end

            ST_OUT: begin
               // wait for the output register to free up
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tvalid_ff <= 1'b1;
                  rsp_tuser_ff  <= full_ff;
                  rsp_tdata_ff  <= {{rcc3d_pkg::RSP_PAD_W{1'b0}},
                                    cov_out_ff[5], cov_out_ff[4], cov_out_ff[3],
                                    cov_out_ff[2], cov_out_ff[1], cov_out_ff[0],
                                    mean_out_ff[2], mean_out_ff[1], mean_out_ff[0],
                                    rcc3d_pkg::sat_count(count_ff)};
                  state_ff      <= ST_IDLE;
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------

   // an accepted point below the limit bumps the count by one
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !full_now) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("count did not advance on an accepted point");

   // the count never passes the limit
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rcc3d_pkg::CNT_W'(rcc3d_pkg::MAX_POINTS))
      else $error("count beyond limit");

   // a dropped-point result only appears once the buffer is full
   a_full_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid_ff && rsp_tuser_ff)
         |-> (count_ff == rcc3d_pkg::CNT_W'(rcc3d_pkg::MAX_POINTS)))
      else $error("full flag with room left");

   // divider partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DITER) |-> (rem_ff < count_ff))
      else $error("divider remainder out of range");

endmodule

/* tb/running_centroid_covariance_3d_unit_tb.sv */
// ----------------------------------------------------------------------------
// running_centroid_covariance_3d_unit_tb: self-checking bench for the unit
// Sends 3-D points as requests and predicts the count, centroid and the
// covariance terms of every result. Both stream sides idle and stall at
// random. Point clusters, noise and corner values drive the stimulus.
// ----------------------------------------------------------------------------
module running_centroid_covariance_3d_unit_tb;

   // Package constants used here
   localparam int  COORD_W      = rcc3d_pkg::COORD_W;
   localparam int  CNT_OUT_W    = rcc3d_pkg::CNT_OUT_W;
   localparam int  MEAN_W       = rcc3d_pkg::MEAN_W;
   localparam int  COV_W        = rcc3d_pkg::COV_W;
   localparam int  NUM_COORDS   = rcc3d_pkg::NUM_COORDS;
   localparam int  NUM_PAIRS    = rcc3d_pkg::NUM_PAIRS;
   localparam int  FRAC_BITS    = rcc3d_pkg::FRAC_BITS;
   localparam int  MAX_POINTS   = rcc3d_pkg::MAX_POINTS;
   localparam int  REQ_DATA_W   = rcc3d_pkg::REQ_DATA_W;
   localparam int  RSP_DATA_W   = rcc3d_pkg::RSP_DATA_W;
   localparam int  RSP_PAD_W    = rcc3d_pkg::RSP_PAD_W;

   // Run control
   localparam int  N_CORNERS    = 18;
   localparam int  N_RANDOM     = 582;
   localparam int  HOLD_AT      = 300;       // random request that triggers the long hold
   localparam int  HOLD_CYCLES  = 3000;      // long receiver stall, several results deep
   localparam int  DRAIN_CYCLES = 600;       // a little over one request's latency
   localparam int  CYCLE_LIMIT  = 1500000;

   // Output ranges
   localparam longint MEAN_HI = (64'sd1 <<< (MEAN_W - 1)) - 64'sd1;
   localparam longint MEAN_LO = -(64'sd1 <<< (MEAN_W - 1));
   localparam longint COV_HI  = (64'sd1 <<< (COV_W - 1)) - 64'sd1;
   localparam longint COV_LO  = -(64'sd1 <<< (COV_W - 1));
   localparam longint CNT_HI  = (64'sd1 <<< CNT_OUT_W) - 64'sd1;

   // One result, as it travels on rsp_tdata / rsp_tuser
   typedef struct packed {
      logic [CNT_OUT_W-1:0]             count;
      logic [NUM_COORDS-1:0][MEAN_W-1:0] mean;   // x, y, z
      logic [NUM_PAIRS-1:0][COV_W-1:0]   cov;    // xx, xy, xz, yy, yz, zz
      logic                              full;
   } stats_type;

   // Row of the corner table; typed rows carry a result readable at a glance
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic                      typed;
      logic [CNT_OUT_W-1:0]      n;
      logic [MEAN_W-1:0]         mx;
      logic [MEAN_W-1:0]         my;
      logic [MEAN_W-1:0]         mz;
   } corner_row_type;

   // Two equal extreme points straight after reset: centroid is the point
   // itself and every covariance term is exactly zero. The rest hit the
   // coordinate extremes, sign flips and alternating bit patterns.
   corner_row_type corner_rows [0:N_CORNERS-1] = '{
      '{-16'sd32768, 16'sd32767, 16'sd0, 1'b1, 17'd1, 24'h800000, 24'h7fff00, 24'h000000},
      '{-16'sd32768, 16'sd32767, 16'sd0, 1'b1, 17'd2, 24'h800000, 24'h7fff00, 24'h000000},
      '{16'sd32767, -16'sd32768, -16'sd1, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{-16'sd32768, -16'sd32768, -16'sd32768, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{16'sd0, 16'sd0, 16'sd0, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{16'sd1, -16'sd1, 16'sd1, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{-16'sd1, 16'sd1, -16'sd1, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{16'sd21845, -16'sd21846, 16'sd21845, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{-16'sd21846, 16'sd21845, -16'sd21846, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{16'sd255, -16'sd256, 16'sd4096, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{-16'sd4096, 16'sd256, -16'sd255, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{16'sd32767, 16'sd0, -16'sd32768, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{-16'sd32768, 16'sd32767, 16'sd32767, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{16'sd12345, -16'sd12345, 16'sd0, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{16'sd0, -16'sd32768, 16'sd32767, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{16'sd100, 16'sd200, 16'sd300, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0},
      '{-16'sd300, -16'sd200, -16'sd100, 1'b0, 17'd0, 24'h0, 24'h0, 24'h0}
   };

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;

   // Predictor state: mirrors the unit's count and running sums
   longint unsigned point_total;
   longint          axis_sum [NUM_COORDS];
   longint          pair_sum [NUM_PAIRS];

   stats_type pending_stats [$];   // expected results, oldest first
   int     mismatch_total;
   int     tx_calm;             // requests left in a no-gap stretch
   int     rx_calm;             // results left in a no-stall stretch
   bit     rx_hold_request;     // asks the receiver for one long hold-off
   int     cycle_count;

   running_centroid_covariance_3d_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Pair order xx, xy, xz, yy, yz, zz
   function automatic int left_axis(input int p);
      return (p < 3) ? 0 : ((p < 5) ? 1 : 2);
   endfunction

   function automatic int right_axis(input int p);
      int r;
      case (p)
         0:       r = 0;
         1, 3:    r = 1;
         default: r = 2;
      endcase
      return r;
   endfunction

   function automatic string axis_letter(input int a);
      string s;
      case (a)
         0:       s = "x";
         1:       s = "y";
         default: s = "z";
      endcase
      return s;
   endfunction

   function automatic longint clamp(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // trunc(num * 2^FRAC_BITS / n), toward zero
   function automatic longint scaled_quotient(input longint num, input longint unsigned n);
      longint unsigned a;
      longint unsigned res;
      if (n == 0) begin
         return 0;
      end
      a   = (num < 0) ? longint'(-num) : num;
      res = (a << FRAC_BITS) / n;
      return (num < 0) ? -longint'(res) : longint'(res);
   endfunction

   // Folds one point into the running sums and returns the expected result
   function automatic stats_type predict_stats(input logic signed [COORD_W-1:0] x,
                                               input logic signed [COORD_W-1:0] y,
                                               input logic signed [COORD_W-1:0] z);
      longint c [NUM_COORDS];
      longint m [NUM_COORDS];
      longint ma, mb, pr, q;
      stats_type s;
      c[0] = x;
      c[1] = y;
      c[2] = z;
      s.full = (point_total >= MAX_POINTS);
      if (!s.full) begin
         point_total++;
         for (int i = 0; i < NUM_COORDS; i++) axis_sum[i] += c[i];
         for (int p = 0; p < NUM_PAIRS; p++) pair_sum[p] += c[left_axis(p)] * c[right_axis(p)];
      end
      s.count = CNT_OUT_W'((point_total > CNT_HI) ? CNT_HI : point_total);
      for (int i = 0; i < NUM_COORDS; i++) begin
         m[i]      = scaled_quotient(axis_sum[i], point_total);
         s.mean[i] = MEAN_W'(clamp(m[i], MEAN_LO, MEAN_HI));
      end
      // centroid product uses the unsaturated means, truncated toward zero
      for (int p = 0; p < NUM_PAIRS; p++) begin
         ma = m[left_axis(p)];
         mb = m[right_axis(p)];
         pr = ((ma < 0 ? -ma : ma) * (mb < 0 ? -mb : mb)) >> FRAC_BITS;
         if ((ma < 0) != (mb < 0)) pr = -pr;
         q  = scaled_quotient(pair_sum[p], point_total);
         s.cov[p] = COV_W'(clamp((point_total == 0) ? 0 : q - pr, COV_LO, COV_HI));
      end
      return s;
   endfunction

   task automatic note_mismatch(input string what, input logic [63:0] want,
                                input logic [63:0] got);
      mismatch_total++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
   endtask

   // Compares one accepted result, field by field, with the oldest expectation
   task automatic check_result(input logic [RSP_DATA_W-1:0] d, input logic flag);
      stats_type got;
      stats_type want;
      got.count = d[CNT_OUT_W-1:0];
      for (int i = 0; i < NUM_COORDS; i++) got.mean[i] = d[CNT_OUT_W + i*MEAN_W +: MEAN_W];
      for (int p = 0; p < NUM_PAIRS; p++) begin
         got.cov[p] = d[CNT_OUT_W + NUM_COORDS*MEAN_W + p*COV_W +: COV_W];
      end
      got.full = flag;
      if (d[RSP_DATA_W-1 -: RSP_PAD_W] != '0) begin
         note_mismatch("pad bits", 0, d[RSP_DATA_W-1 -: RSP_PAD_W]);
      end
      if (pending_stats.size() == 0) begin
         note_mismatch("unrequested result, point_count", 0, got.count);
      end else begin
         want = pending_stats.pop_front();
         if (got.count != want.count) note_mismatch("point_count", want.count, got.count);
         for (int i = 0; i < NUM_COORDS; i++) begin
            if (got.mean[i] != want.mean[i]) begin
               note_mismatch({"mean_", axis_letter(i)}, want.mean[i], got.mean[i]);
            end
         end
         for (int p = 0; p < NUM_PAIRS; p++) begin
            if (got.cov[p] != want.cov[p]) begin
               note_mismatch({"cov_", axis_letter(left_axis(p)), axis_letter(right_axis(p))},
                             want.cov[p], got.cov[p]);
            end
         end
         if (got.full != want.full) note_mismatch("full_flag", want.full, got.full);
      end
   endtask

   // Offers one point, waits for its handshake and files the expectation.
   // Entered and left at a falling edge; valid stays high when no gap is drawn.
   task automatic offer_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z,
                              input bit use_typed, input stats_type typed);
      int        gap;
      stats_type want;
      if (tx_calm == 0 && $urandom_range(0, 7) == 0) tx_calm = $urandom_range(4, 24);
      if (tx_calm > 0) begin
         gap = 0;
         tx_calm--;
      end else begin
         gap = $urandom_range(0, 15);
      end
      if (gap > 0) begin
         req_tvalid = 1'b0;
         // sometimes start the gap only once the unit is waiting for a request
         if ($urandom_range(0, 1) == 1) begin
            do @(posedge clock); while (!req_tready);
            @(negedge clock);
         end
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {z, y, x};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      want = predict_stats(x, y, z);
      pending_stats.push_back(use_typed ? typed : want);
      @(negedge clock);
   endtask

   function automatic logic signed [COORD_W-1:0] near_point(input int centre, input int spread);
      int v;
      v = centre + int'($urandom_range(0, 2 * spread)) - spread;
      return COORD_W'(clamp(v, -32768, 32767));
   endfunction

   // ---------------------------------------------------------------------
   // Request side: reset, corner table, a drain pause, then random points.
   // full_flag cannot be reached here: the run sends far fewer requests than
   // the MAX_POINTS it takes to fill the unit, so it is only checked low.
   // ---------------------------------------------------------------------
   initial begin : request_side
      stats_type typed;
      int     centre [NUM_COORDS];
      int     spread;
      int     burst_left;
      int     kind;
      logic signed [COORD_W-1:0] pt [NUM_COORDS];

      reset           = 1'b1;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      point_total     = 0;
      mismatch_total  = 0;
      tx_calm         = 0;
      burst_left      = 0;
      spread          = 0;
      for (int i = 0; i < NUM_COORDS; i++) begin
         axis_sum[i] = 0;
         centre[i]   = 0;
      end
      for (int p = 0; p < NUM_PAIRS; p++) pair_sum[p] = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corner table
      for (int r = 0; r < N_CORNERS; r++) begin
         typed       = '0;
         typed.count = corner_rows[r].n;
         typed.mean  = {corner_rows[r].mz, corner_rows[r].my, corner_rows[r].mx};
         offer_point(corner_rows[r].x, corner_rows[r].y, corner_rows[r].z,
                     corner_rows[r].typed, typed);
      end

      // sender pause: let every outstanding result come back first
      req_tvalid = 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      @(negedge clock);

      // random part: mostly clusters around a drifting centre, some noise
      for (int k = 0; k < N_RANDOM; k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(8, 40);
            for (int i = 0; i < NUM_COORDS; i++) centre[i] = $signed(16'($urandom));
            case ($urandom_range(0, 2))
               0:       spread = 4;
               1:       spread = 256;
               default: spread = 8192;
            endcase
         end
         burst_left--;
         kind = $urandom_range(0, 9);
         for (int i = 0; i < NUM_COORDS; i++) begin
            if (kind < 2)       pt[i] = $signed(16'($urandom));
            else if (kind == 2) pt[i] = near_point(0, 8);
            else                pt[i] = near_point(centre[i], spread);
         end
         // receiver holds off for a long stretch while requests keep coming
         if (k == HOLD_AT) rx_hold_request = 1'b1;
         offer_point(pt[0], pt[1], pt[2], 1'b0, '0);
      end
      req_tvalid = 1'b0;

      while (pending_stats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Result side: random stalls, calm stretches and one long hold-off
   initial begin : result_side
      int stall;
      rsp_tready      = 1'b0;
      rx_calm         = 0;
      rx_hold_request = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rx_calm == 0 && $urandom_range(0, 7) == 0) rx_calm = $urandom_range(4, 24);
         if (rx_hold_request) begin
            stall           = HOLD_CYCLES;
            rx_hold_request = 1'b0;
         end else if (rx_calm > 0) begin
            stall = 0;
            rx_calm--;
         end else begin
            stall = $urandom_range(0, 15);
         end
         if (stall > 0) begin
            rsp_tready = 1'b0;
            // half the time the stall starts when the result shows up
            if ($urandom_range(0, 1) == 1) begin
               do @(posedge clock); while (!rsp_tvalid);
               @(negedge clock);
            end
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         check_result(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   // Watchdog
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule

/* running_centroid_covariance_3d_unit.f */
design/rcc3d_pkg.sv
design/running_centroid_covariance_3d_unit.sv
tb/running_centroid_covariance_3d_unit_tb.sv
